@@ hw/rtl/npc_trig_pkg.sv @@
// Shared types, constants and helpers for the nested hit counter trigger.
`default_nettype none
package npc_trig_pkg;

	localparam int DEPTH_DEF  = 8;
	localparam int CNT_W      = 32;
	localparam int ADDR_W     = 64;
	localparam int OPC_W      = 2;
	localparam int EIDX_W     = 3;
	localparam int ACT_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 1'd1;

	typedef enum logic [OPC_W-1:0] {
		OP_OBSERVE = 2'd0,
		OP_LOAD    = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic latch;
		logic eval;
		logic update;
	} ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/npc_trig_ctrl.sv @@
// Request sequencer: accept, compare, update, then strobe the result.
`default_nettype none
module npc_trig_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	output logic                     done,
	output npc_trig_pkg::ctl_t       ctl
);

	npc_trig_pkg::state_t state_q, state_nx;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npc_trig_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= ctl.update;
		end
	end

	always_comb begin
		state_nx   = state_q;
		ctl        = '0;
		busy       = 1'b1;
		case (state_q)
			npc_trig_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.latch = 1'b1;
					state_nx  = npc_trig_pkg::ST_MATCH;
				end
			end
			npc_trig_pkg::ST_MATCH: begin
				ctl.eval = 1'b1;
				state_nx = npc_trig_pkg::ST_UPDATE;
			end
			npc_trig_pkg::ST_UPDATE: begin
				ctl.update = 1'b1;
				state_nx   = npc_trig_pkg::ST_IDLE;
			end
			default: begin
				state_nx = npc_trig_pkg::ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule
`default_nettype wire

@@ hw/rtl/npc_trig_dp.sv @@
// Datapath: entry list, per-entry hit counters, tail counter and result registers.
`default_nettype none
module npc_trig_dp #(
	parameter int DEPTH = npc_trig_pkg::DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire npc_trig_pkg::ctl_t                    ctl,
	input  wire logic                                  cfg_we,
	input  wire logic [npc_trig_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [npc_trig_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [npc_trig_pkg::OPC_W-1:0]        opcode,
	input  wire logic [npc_trig_pkg::ADDR_W-1:0]       address,
	input  wire logic [npc_trig_pkg::EIDX_W-1:0]       entry_index,
	output logic                                       matched,
	output logic [npc_trig_pkg::EIDX_W-1:0]            match_index,
	output logic [npc_trig_pkg::CNT_W-1:0]             count_value,
	output logic [npc_trig_pkg::CNT_W-1:0]             tail_hits,
	output logic                                       halted
);

	localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW0 = $clog2(DEPTH + 1);
	localparam int NW  = (NW0 > npc_trig_pkg::ACT_W) ? NW0 : npc_trig_pkg::ACT_W;

	logic [npc_trig_pkg::CNT_W-1:0]  expected_q;
	logic [npc_trig_pkg::ACT_W-1:0]  active_q;
	logic [npc_trig_pkg::OPC_W-1:0]  op_q;
	logic [npc_trig_pkg::ADDR_W-1:0] addr_q;
	logic [npc_trig_pkg::EIDX_W-1:0] idx_q;
	logic [npc_trig_pkg::ADDR_W-1:0] ent_addr_q [DEPTH];
	logic [npc_trig_pkg::CNT_W-1:0]  hits_q [DEPTH];
	logic [DEPTH-1:0]                hit_oh_q;
	logic [IW-1:0]                   hit_idx_q;
	logic                            any_q;
	logic                            tail_hit_q;
	logic [npc_trig_pkg::CNT_W-1:0]  tail_q;
	logic                            stop_q;
	logic                            matched_q;
	logic [npc_trig_pkg::EIDX_W-1:0] match_index_q;
	logic [npc_trig_pkg::CNT_W-1:0]  count_q;

	logic [NW-1:0]                   live_n;
	logic [DEPTH-1:0]                lane_on;
	logic [DEPTH-1:0]                eq;
	logic [DEPTH-1:0]                eq_low;
	logic [IW-1:0]                   eq_idx;
	logic                            idx_ok;
	logic [IW-1:0]                   widx;
	logic                            do_obs;
	logic                            counted;
	logic [npc_trig_pkg::CNT_W-1:0]  hit_new;
	logic [npc_trig_pkg::CNT_W-1:0]  tail_new;

	always_comb begin
		if (active_q == '0) begin
			live_n = NW'(1);
		end else if (int'(active_q) > DEPTH) begin
			live_n = NW'(DEPTH);
		end else begin
			live_n = NW'(active_q);
		end
	end

	always_comb begin
		eq_idx = '0;
		for (int k = 0; k < DEPTH; k++) begin
			lane_on[k] = (k < int'(live_n));
			eq[k]      = lane_on[k] && (ent_addr_q[k] == addr_q);
		end
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if (eq[k]) begin
				eq_idx = IW'(k);
			end
		end
		eq_low = eq & (~eq + DEPTH'(1));
	end

	assign idx_ok   = (int'(idx_q) < DEPTH);
	assign widx     = IW'(idx_q);
	assign do_obs   = (op_q == npc_trig_pkg::OP_OBSERVE) && !stop_q;
	assign counted  = do_obs && any_q;
	assign hit_new  = npc_trig_pkg::sat_inc(hits_q[hit_idx_q]);
	assign tail_new = (counted && tail_hit_q) ? npc_trig_pkg::sat_inc(tail_q) : tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= npc_trig_pkg::CNT_W'(1);
			active_q   <= npc_trig_pkg::ACT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				npc_trig_pkg::REG_EXPECTED: expected_q <= cfg_data;
				npc_trig_pkg::REG_ACTIVE:   active_q <= cfg_data[npc_trig_pkg::ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			op_q   <= opcode;
			addr_q <= address;
			idx_q  <= entry_index;
		end
		if (ctl.eval) begin
			hit_oh_q   <= eq_low;
			hit_idx_q  <= eq_idx;
			any_q      <= |eq;
			tail_hit_q <= (int'(eq_idx) == int'(live_n) - 1);
		end
		if (ctl.update && (op_q == npc_trig_pkg::OP_LOAD) && !stop_q && idx_ok) begin
			ent_addr_q[widx] <= addr_q;
		end
		if (ctl.update) begin
			matched_q     <= counted;
			match_index_q <= counted ? npc_trig_pkg::EIDX_W'(hit_idx_q) : '0;
			if (counted) begin
				count_q <= hit_new;
			end else if ((op_q == npc_trig_pkg::OP_READ) && idx_ok) begin
				count_q <= hits_q[widx];
			end else begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				hits_q[k] <= '0;
			end
			tail_q <= '0;
			stop_q <= 1'b0;
		end else if (ctl.update && counted) begin
			for (int k = 0; k < DEPTH; k++) begin
				if (hit_oh_q[k]) begin
					hits_q[k] <= hit_new;
				end else if (lane_on[k] && (k > int'(hit_idx_q))) begin
					hits_q[k] <= '0;
				end
			end
			tail_q <= tail_new;
			if (tail_new >= expected_q) begin
				stop_q <= 1'b1;
			end
		end
	end

	assign matched     = matched_q;
	assign match_index = match_index_q;
	assign count_value = count_q;
	assign tail_hits   = tail_q;
	assign halted      = stop_q;

endmodule
`default_nettype wire

@@ hw/rtl/nested_pc_hit_counter_trigger.sv @@
// Top level of the nested hit counter trigger: sequencer, datapath and checks.
`default_nettype none
// A request is taken when start is high and busy is low. After that, busy
// stays high for the compare cycle (all active entries checked against the
// address in parallel, lowest index wins) and the update cycle (counter
// increment, masked clear of later entries, tail count and halt check); done
// then pulses for one cycle with the result on the result ports, and a new
// request may be taken in that same cycle. The receiver cannot stall and must
// take each result during its done cycle. tail_hits and halted also show the
// live state between results. Configuration writes apply at once and belong in
// periods when no request is in flight.
module nested_pc_hit_counter_trigger #(
	parameter int DEPTH = npc_trig_pkg::DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	output logic                                       done,
	input  wire logic                                  cfg_we,
	input  wire logic [npc_trig_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [npc_trig_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [npc_trig_pkg::OPC_W-1:0]        opcode,
	input  wire logic [npc_trig_pkg::ADDR_W-1:0]       address,
	input  wire logic [npc_trig_pkg::EIDX_W-1:0]       entry_index,
	output logic                                       matched,
	output logic [npc_trig_pkg::EIDX_W-1:0]            match_index,
	output logic [npc_trig_pkg::CNT_W-1:0]             count_value,
	output logic [npc_trig_pkg::CNT_W-1:0]             tail_hits,
	output logic                                       halted
);

	npc_trig_pkg::ctl_t ctl;

	npc_trig_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	npc_trig_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.address     (address),
		.entry_index (entry_index),
		.matched     (matched),
		.match_index (match_index),
		.count_value (count_value),
		.tail_hits   (tail_hits),
		.halted      (halted)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted |=> halted)
		else $error("halt released");

	a_match_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && matched) |-> (count_value != '0))
		else $error("matched request with zero count");

	a_tail_steady_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start && !done) |=> $stable(tail_hits))
		else $error("tail count moved while idle");

endmodule
`default_nettype wire

@@ bench/trigger_monitor.sv @@
// Monitor for the hit counter trigger: predicts each result and compares it.
`default_nettype none
module trigger_monitor
	import npc_trig_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic                  done,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [OPC_W-1:0]      opcode,
	input  wire logic [ADDR_W-1:0]     address,
	input  wire logic [EIDX_W-1:0]     entry_index,
	input  wire logic                  matched,
	input  wire logic [EIDX_W-1:0]     match_index,
	input  wire logic [CNT_W-1:0]      count_value,
	input  wire logic [CNT_W-1:0]      tail_hits,
	input  wire logic                  halted,
	output int                         pending,
	output int                         fail_count
);

	typedef struct packed {
		logic              matched;
		logic [EIDX_W-1:0] match_index;
		logic [CNT_W-1:0]  count_value;
		logic [CNT_W-1:0]  tail_hits;
		logic              halted;
	} hit_report_t;

	hit_report_t       reports_due[$];
	logic [ADDR_W-1:0] slot_addr [DEPTH_DEF];
	logic [CNT_W-1:0]  slot_hits [DEPTH_DEF];
	logic [CNT_W-1:0]  tail_tally;
	logic              stopped;
	logic [CNT_W-1:0]  goal;
	logic [ACT_W-1:0]  act;
	int                bad;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

	task automatic count_hit(input op_t op, input logic [ADDR_W-1:0] a,
			input logic [EIDX_W-1:0] ix, output hit_report_t r);
		int live;
		int hit;
		r = '0;
		live = (act == 0) ? 1 : (act > DEPTH_DEF) ? DEPTH_DEF : int'(act);
		if (op == OP_OBSERVE && !stopped) begin
			hit = -1;
			for (int i = 0; i < DEPTH_DEF; i++)
				if (hit < 0 && i < live && slot_addr[i] == a)
					hit = i;
			if (hit >= 0) begin
				slot_hits[hit] = bump(slot_hits[hit]);
				for (int k = 0; k < DEPTH_DEF; k++)
					if (k > hit && k < live)
						slot_hits[k] = '0;
				if (hit == live - 1)
					tail_tally = bump(tail_tally);
				if (tail_tally >= goal)
					stopped = 1'b1;
				r.matched = 1'b1;
				r.match_index = EIDX_W'(hit);
				r.count_value = slot_hits[hit];
			end
		end else if (op == OP_LOAD && !stopped) begin
			slot_addr[ix] = a;
		end else if (op == OP_READ) begin
			r.count_value = slot_hits[ix];
		end
		r.tail_hits = tail_tally;
		r.halted = stopped;
	endtask

	task automatic compare_field(input string what, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s expected %h actual %h", $time, what, want, got);
			bad++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		hit_report_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH_DEF; i++) begin
				slot_addr[i] = '0;
				slot_hits[i] = '0;
			end
			tail_tally = '0;
			stopped = 1'b0;
			goal = CNT_W'(1);
			act = ACT_W'(1);
			bad = 0;
			reports_due.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (reports_due.size() == 0) begin
					$display("%0t result with no request outstanding", $time);
					bad++;
				end else begin
					want = reports_due.pop_front();
					compare_field("matched", CNT_W'(want.matched), CNT_W'(matched));
					compare_field("match_index", CNT_W'(want.match_index),
						CNT_W'(match_index));
					compare_field("count_value", want.count_value, count_value);
					compare_field("tail_hits", want.tail_hits, tail_hits);
					compare_field("halted", CNT_W'(want.halted), CNT_W'(halted));
				end
			end
			if (start && !busy) begin
				count_hit(op_t'(opcode), address, entry_index, want);
				reports_due.insert(reports_due.size(), want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_EXPECTED: goal = cfg_data;
					REG_ACTIVE: act = cfg_data[ACT_W-1:0];
					default: ;
				endcase
			end
			pending <= reports_due.size();
			fail_count <= bad;
		end
	end

endmodule
`default_nettype wire

@@ bench/nested_pc_hit_counter_trigger_test.sv @@
// Testbench top for the hit counter trigger: stimulus, watchdog and verdict.
`default_nettype none
module nested_pc_hit_counter_trigger_test;
	import npc_trig_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  done;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic [OPC_W-1:0]      opcode = '0;
	logic [ADDR_W-1:0]     address = '0;
	logic [EIDX_W-1:0]     entry_index = '0;
	logic                  matched;
	logic [EIDX_W-1:0]     match_index;
	logic [CNT_W-1:0]      count_value;
	logic [CNT_W-1:0]      tail_hits;
	logic                  halted;
	int                    pending;
	int                    fail_count;

	logic [ADDR_W-1:0]     entry_tab [DEPTH_DEF];
	int                    eff = 1;
	int                    idle_pct = 0;
	int                    quiet = 0;

	nested_pc_hit_counter_trigger dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.opcode(opcode), .address(address), .entry_index(entry_index),
		.matched(matched), .match_index(match_index), .count_value(count_value),
		.tail_hits(tail_hits), .halted(halted)
	);

	trigger_monitor monitor (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.opcode(opcode), .address(address), .entry_index(entry_index),
		.matched(matched), .match_index(match_index), .count_value(count_value),
		.tail_hits(tail_hits), .halted(halted),
		.pending(pending), .fail_count(fail_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAIL nested_pc_hit_counter_trigger");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_req(input op_t op, input logic [ADDR_W-1:0] a,
			input logic [EIDX_W-1:0] ix);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			opcode <= OPC_W'($urandom);
			address <= {$urandom, $urandom};
			entry_index <= EIDX_W'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		address <= a;
		entry_index <= ix;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_active(input logic [ACT_W-1:0] v);
		logic [CFG_DATA_W-1:0] d;
		d = $urandom;
		d[ACT_W-1:0] = v;
		cfg_write(REG_ACTIVE, d);
		eff = (v == 0) ? 1 : (v > DEPTH_DEF) ? DEPTH_DEF : int'(v);
	endtask

	task automatic run_random(input int n);
		int issued;
		int pick;
		int e;
		issued = 0;
		while (issued < n) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_req(OP_OBSERVE, entry_tab[$urandom_range(DEPTH_DEF - 1)], EIDX_W'($urandom));
				issued++;
			end else if (pick < 60) begin
				for (e = 0; e < eff; e++)
					send_req(OP_OBSERVE, entry_tab[e], EIDX_W'($urandom));
				issued += eff;
			end else if (pick < 70) begin
				send_req(OP_OBSERVE, {$urandom, $urandom}, EIDX_W'($urandom));
				issued++;
			end else if (pick < 78) begin
				e = $urandom_range(DEPTH_DEF - 1);
				entry_tab[e] = {$urandom, $urandom};
				send_req(OP_LOAD, entry_tab[e], EIDX_W'(e));
				issued++;
			end else if (pick < 93) begin
				send_req(OP_READ, {$urandom, $urandom}, EIDX_W'($urandom));
				issued++;
			end else begin
				send_req(OP_NONE, {$urandom, $urandom}, EIDX_W'($urandom));
				issued++;
			end
		end
	endtask

	initial begin : stimulus
		logic [ACT_W-1:0]      act_plan [12];
		logic [CFG_DATA_W-1:0] goal_plan [3];
		act_plan = '{4'd8, 4'd1, 4'd0, 4'd5, 4'd15, 4'd3, 4'd2, 4'd8, 4'd7, 4'd4, 4'd6, 4'd8};
		goal_plan[0] = 32'hFFFF_FFFF;
		goal_plan[1] = 32'h8000_0000 | $urandom;
		goal_plan[2] = 32'h0001_0000 + $urandom_range(16'hFFFF);
		entry_tab[0] = '0;
		entry_tab[1] = '1;
		entry_tab[2] = 64'hAAAA_AAAA_AAAA_AAAA;
		entry_tab[3] = 64'h5555_5555_5555_5555;
		for (int i = 4; i < DEPTH_DEF; i++)
			entry_tab[i] = {$urandom, $urandom};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_write(REG_EXPECTED, goal_plan[0]);
		set_active(4'd8);
		for (int i = 0; i < DEPTH_DEF; i++)
			send_req(OP_LOAD, entry_tab[i], EIDX_W'(i));
		send_req(OP_OBSERVE, entry_tab[7], 3'd0);
		send_req(OP_OBSERVE, entry_tab[0], 3'd7);
		send_req(OP_OBSERVE, entry_tab[3], 3'd0);
		send_req(OP_OBSERVE, {$urandom, $urandom}, 3'd0);
		send_req(OP_READ, '0, 3'd0);
		send_req(OP_READ, '1, 3'd3);
		send_req(OP_READ, '0, 3'd7);
		send_req(OP_NONE, '1, 3'd7);
		// duplicate address: lower entry must win
		send_req(OP_LOAD, entry_tab[2], 3'd5);
		send_req(OP_OBSERVE, entry_tab[2], 3'd5);
		send_req(OP_LOAD, entry_tab[5], 3'd5);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 17 : (ph == 1) ? 47 : 0;
			for (int blk = 0; blk < 4; blk++) begin
				settle();
				set_active(act_plan[ph * 4 + blk]);
				if (blk == 0)
					cfg_write(REG_EXPECTED, goal_plan[ph]);
				run_random(67);
			end
		end

		// drive the tail up to the threshold, then exercise the halted state
		settle();
		cfg_write(REG_EXPECTED, tail_hits + 3);
		for (int g = 0; g < 20 && !halted; g++)
			send_req(OP_OBSERVE, entry_tab[eff - 1], EIDX_W'($urandom));
		run_random(40);
		settle();
		cfg_write(REG_EXPECTED, '0);
		set_active(4'd15);
		run_random(20);

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS nested_pc_hit_counter_trigger");
		else
			$display("FAIL nested_pc_hit_counter_trigger");
		$finish;
	end

endmodule
`default_nettype wire
